[sv/jfps_pkg.sv]
// Shared constants and types for the five-point stencil block.
`default_nettype none
package jfps_pkg;

    localparam int VALUE_BITS     = 32;
    localparam int MAX_ROW_LENGTH = 512;
    localparam int ADDR_W         = $clog2(MAX_ROW_LENGTH);
    localparam int LEN_W          = 10;
    localparam int ROWS_W         = 16;
    localparam int COL_W          = 9;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 16;
    localparam int OUT_FIELDS_W   = VALUE_BITS + ROWS_W + COL_W;
    localparam int OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int IN_TDATA_W     = ((VALUE_BITS + 7) / 8) * 8;
    localparam int OUTQ_DEPTH     = 4;
    localparam int OUTQ_PTR_W     = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_LVL_W     = $clog2(OUTQ_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = CFG_IDX_W'(1);

    localparam logic [LEN_W-1:0]  ROW_LENGTH_RESET = LEN_W'(512);
    localparam logic [ROWS_W-1:0] ROW_COUNT_RESET  = ROWS_W'(512);
    localparam logic [LEN_W-1:0]  MIN_LEN          = LEN_W'(3);
    localparam logic [LEN_W-1:0]  MAX_LEN          = LEN_W'(MAX_ROW_LENGTH);
    localparam logic [ROWS_W-1:0] MIN_ROWS         = ROWS_W'(3);
    localparam int                FIRST_INTERIOR   = 2;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [VALUE_BITS:0]   pair_sum_t;

    typedef struct packed {
        logic [ROWS_W-1:0] row;
        logic [COL_W-1:0]  col;
        logic              last;
    } tag_t;

    typedef struct packed {
        tag_t   tag;
        value_t average;
    } result_t;

endpackage
`default_nettype wire

[sv/jfps_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module jfps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

[sv/jfps_cell.sv]
// One window cell: holds a grid value and hands it on when the window shifts.
`default_nettype none
module jfps_cell (
    input  wire logic             aclk,
    input  wire logic             shift_en,
    input  wire jfps_pkg::value_t d,
    output jfps_pkg::value_t      q
);
    import jfps_pkg::*;

    value_t value_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            value_reg <= d;
        end
    end

    assign q = value_reg;
endmodule
`default_nettype wire

[sv/jfps_outq.sv]
// Small result queue that decouples the stencil pipe from the output channel.
`default_nettype none
module jfps_outq (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               push,
    input  wire jfps_pkg::result_t                  push_data,
    input  wire logic                               pop_ready,
    output logic                                    out_valid,
    output jfps_pkg::result_t                       out_data,
    output logic [jfps_pkg::OUTQ_LVL_W-1:0]         level
);
    import jfps_pkg::*;

    result_t               entry_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wptr_reg, wptr_next;
    logic [OUTQ_PTR_W-1:0] rptr_reg, rptr_next;
    logic [OUTQ_LVL_W-1:0] count_reg, count_next;
    logic                  pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid & pop_ready;
    assign out_data  = entry_reg[rptr_reg];
    assign level     = count_reg;

    always_comb begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop  ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

[sv/jacobi_five_point_stencil.sv]
// Streaming five-point Jacobi stencil: four-neighbor average of a raster-order grid.
//
// Grid values enter on the s_axis channel in row-major order, one beat per value.
// For every interior point (r, c) a beat leaves on m_axis holding the quarter of
// north + south + east + west (floor of the exact sum), the row and column of
// the point, and tlast on the final interior point of the grid. Boundary rows
// and columns give no beat. The result for (r, c) leaves once value (r+1, c+1)
// is in. Grid size comes from row_length (index 0) and row_count (index 1) on
// the cfg port; write them only while no beat is in flight.
// Throughput is one value per cycle while s_axis_tready is high. A result beat
// is offered once the completing value has passed the line buffer read, the final
// add and the write into the result queue. Two line buffers (one RAM row each)
// and four window cells carry the two previous rows.
// A four-entry result queue absorbs receiver stalls; s_axis_tready drops when
// the queue plus the two pipe stages could overflow, and returns as soon as the
// receiver drains a beat. Reset clears position, pipe and queue and restores
// both registers to 512; line buffer contents are left as they are.
`default_nettype none
module jacobi_five_point_stencil (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [jfps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [31:0] sample
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic      [jfps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [31:0] average,
                                                                    // [47:32] out_row,
                                                                    // [56:48] out_col
    output logic                                     m_axis_tlast,
    input  wire logic                                cfg_we,
    input  wire logic [jfps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [jfps_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import jfps_pkg::*;

    logic [LEN_W-1:0]      row_length_reg;
    logic [ROWS_W-1:0]     row_count_reg;
    logic [LEN_W-1:0]      len_eff;
    logic [ROWS_W-1:0]     rows_eff;

    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROWS_W-1:0]     row_reg, row_next;
    logic [COL_W-1:0]      pos_col;
    logic [ROWS_W-1:0]     pos_row;
    logic [ROWS_W:0]       row_wrap;
    logic [ROWS_W:0]       row_inc;
    logic [LEN_W-1:0]      col_inc;
    logic                  s_acc;
    logic                  produce;
    tag_t                  tag;

    logic                  b_valid_reg;
    logic                  b_prod_reg;
    tag_t                  b_tag_reg;
    logic [ADDR_W-1:0]     b_addr_reg;
    value_t                b_sample_reg;

    value_t                north_rd, middle_rd;
    value_t                north_q, south_q, mid0_q, mid1_q;
    pair_sum_t             p1, p2;

    logic                  c_valid_reg;
    tag_t                  c_tag_reg;
    pair_sum_t             c_p1_reg, c_p2_reg;
    logic [VALUE_BITS+1:0] full_sum;
    result_t               push_data, out_data;
    logic [OUTQ_LVL_W-1:0] level;
    logic [OUTQ_LVL_W-1:0] occupancy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg <= ROW_LENGTH_RESET;
            row_count_reg  <= ROW_COUNT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ROW_LENGTH: row_length_reg <= cfg_data[LEN_W-1:0];
                REG_ROW_COUNT:  row_count_reg  <= cfg_data[ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        len_eff = row_length_reg;
        if (row_length_reg < MIN_LEN) begin
            len_eff = MIN_LEN;
        end else if (row_length_reg > MAX_LEN) begin
            len_eff = MAX_LEN;
        end
        rows_eff = (row_count_reg < MIN_ROWS) ? MIN_ROWS : row_count_reg;
    end

    // wrap a position left outside the grid by a register write
    always_comb begin
        if (LEN_W'(col_reg) >= len_eff) begin
            pos_col  = '0;
            row_wrap = (ROWS_W + 1)'(row_reg) + 1'b1;
        end else begin
            pos_col  = col_reg;
            row_wrap = (ROWS_W + 1)'(row_reg);
        end
        pos_row = (row_wrap >= (ROWS_W + 1)'(rows_eff)) ? '0 : row_wrap[ROWS_W-1:0];

        col_inc = LEN_W'(pos_col) + 1'b1;
        row_inc = (ROWS_W + 1)'(pos_row) + 1'b1;
        if (col_inc >= len_eff) begin
            col_next = '0;
            row_next = (row_inc >= (ROWS_W + 1)'(rows_eff)) ? '0 : row_inc[ROWS_W-1:0];
        end else begin
            col_next = col_inc[COL_W-1:0];
            row_next = pos_row;
        end
    end

    assign produce  = (pos_row >= ROWS_W'(FIRST_INTERIOR)) &&
                      (pos_col >= COL_W'(FIRST_INTERIOR));
    assign tag.row  = pos_row - 1'b1;
    assign tag.col  = pos_col - 1'b1;
    assign tag.last = (pos_row == rows_eff - 1'b1) && (LEN_W'(pos_col) == len_eff - 1'b1);

    assign occupancy     = level + OUTQ_LVL_W'(b_valid_reg) + OUTQ_LVL_W'(c_valid_reg);
    assign s_axis_tready = occupancy < OUTQ_LVL_W'(OUTQ_DEPTH);
    assign s_acc         = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            b_valid_reg <= s_acc;
            c_valid_reg <= b_valid_reg & b_prod_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            b_prod_reg   <= produce;
            b_tag_reg    <= tag;
            b_addr_reg   <= ADDR_W'(pos_col);
            b_sample_reg <= s_axis_tdata[VALUE_BITS-1:0];
        end
        c_tag_reg <= b_tag_reg;
        c_p1_reg  <= p1;
        c_p2_reg  <= p2;
    end

    jfps_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ROW_LENGTH)) u_newer_row (
        .aclk  (aclk),
        .we    (s_acc),
        .waddr (ADDR_W'(pos_col)),
        .wdata (s_axis_tdata[VALUE_BITS-1:0]),
        .raddr (ADDR_W'(pos_col)),
        .rdata (middle_rd)
    );

    jfps_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ROW_LENGTH)) u_older_row (
        .aclk  (aclk),
        .we    (b_valid_reg),
        .waddr (b_addr_reg),
        .wdata (middle_rd),
        .raddr (ADDR_W'(pos_col)),
        .rdata (north_rd)
    );

    jfps_cell u_north_cell (.aclk(aclk), .shift_en(b_valid_reg), .d(north_rd),     .q(north_q));
    jfps_cell u_south_cell (.aclk(aclk), .shift_en(b_valid_reg), .d(b_sample_reg), .q(south_q));
    jfps_cell u_mid0_cell  (.aclk(aclk), .shift_en(b_valid_reg), .d(middle_rd),    .q(mid0_q));
    jfps_cell u_mid1_cell  (.aclk(aclk), .shift_en(b_valid_reg), .d(mid0_q),       .q(mid1_q));

    assign p1 = {north_q[VALUE_BITS-1], north_q} + {south_q[VALUE_BITS-1], south_q};
    assign p2 = {mid1_q[VALUE_BITS-1], mid1_q} + {middle_rd[VALUE_BITS-1], middle_rd};

    assign full_sum          = {c_p1_reg[VALUE_BITS], c_p1_reg} + {c_p2_reg[VALUE_BITS], c_p2_reg};
    assign push_data.tag     = c_tag_reg;
    assign push_data.average = full_sum[VALUE_BITS+1:2];

    jfps_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (c_valid_reg),
        .push_data (push_data),
        .pop_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (out_data),
        .level     (level)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                           out_data.tag.col, out_data.tag.row, out_data.average};
    assign m_axis_tlast = out_data.tag.last;
endmodule
`default_nettype wire

[sv/jfps_checker.sv]
// Port-level checks for the stencil block, bound to the top level.
`default_nettype none
module jfps_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [jfps_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input wire logic                              m_axis_tlast
);
    import jfps_pkg::*;

    localparam int ROW_LO = VALUE_BITS;
    localparam int COL_LO = VALUE_BITS + ROWS_W;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result beat offered right after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("stalled result beat changed or dropped");

    a_interior_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[COL_LO+COL_W-1:COL_LO] != '0)
            && (m_axis_tdata[ROW_LO+ROWS_W-1:ROW_LO] != '0))
        else $error("result beat for a boundary point");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] == '0)
        else $error("padding bits of result beat not zero");
endmodule

bind jacobi_five_point_stencil jfps_checker u_jfps_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

[tb/sv/jfps_stencil_checker.sv]
// Stream checker for the five-point stencil: predicts every average and compares result beats.
`timescale 1ns / 1ps
module jfps_stencil_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic [jfps_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [31:0] sample
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [jfps_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [31:0] average,
                                                                 // [47:32] out_row,
                                                                 // [56:48] out_col
    input  logic                                 m_axis_tlast,
    input  logic                                 cfg_we,
    input  logic [jfps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [jfps_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                   fault_count,
    output int                                   awaited,
    output int                                   averages_checked
);
    import jfps_pkg::*;

    logic [LEN_W-1:0]  row_length = ROW_LENGTH_RESET;
    logic [ROWS_W-1:0] row_count  = ROW_COUNT_RESET;
    value_t            older_line [MAX_ROW_LENGTH];
    value_t            newer_line [MAX_ROW_LENGTH];
    value_t            mid_near, mid_far, left_value, north_hold;
    int                pos_row, pos_col;
    int                faults, matched;
    result_t           pending_averages [$];

    function automatic int grid_width();
        if (row_length < MIN_LEN) return int'(MIN_LEN);
        if (row_length > MAX_LEN) return int'(MAX_LEN);
        return int'(row_length);
    endfunction

    function automatic int grid_height();
        if (row_count < MIN_ROWS) return int'(MIN_ROWS);
        return int'(row_count);
    endfunction

    task automatic take_sample(input value_t sample);
        int                         w, h, c, r;
        value_t                     north_c, middle_c;
        logic signed [VALUE_BITS+1:0] total;
        result_t                    point;
        w = grid_width();
        h = grid_height();
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= h) pos_row = 0;
        c = pos_col;
        r = pos_row;

        north_c       = older_line[c];
        middle_c      = newer_line[c];
        older_line[c] = middle_c;
        newer_line[c] = sample;

        if (r >= FIRST_INTERIOR && c >= FIRST_INTERIOR) begin
            total = $signed(north_hold) + $signed(left_value) + $signed(mid_far)
                  + $signed(middle_c);
            point.average  = total[VALUE_BITS+1:2];
            point.tag.row  = ROWS_W'(r - 1);
            point.tag.col  = COL_W'(c - 1);
            point.tag.last = (r == h - 1) && (c == w - 1);
            pending_averages.push_back(point);
        end

        mid_far    = mid_near;
        mid_near   = middle_c;
        north_hold = north_c;
        left_value = sample;

        pos_col = c + 1;
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row = r + 1;
            if (pos_row >= h) pos_row = 0;
        end
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            row_length = ROW_LENGTH_RESET;
            row_count  = ROW_COUNT_RESET;
            foreach (older_line[i]) older_line[i] = '0;
            foreach (newer_line[i]) newer_line[i] = '0;
            mid_near   = '0;
            mid_far    = '0;
            left_value = '0;
            north_hold = '0;
            pos_row    = 0;
            pos_col    = 0;
            pending_averages.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_ROW_LENGTH: row_length = cfg_data[LEN_W-1:0];
                    REG_ROW_COUNT:  row_count  = cfg_data[ROWS_W-1:0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) take_sample(s_axis_tdata[VALUE_BITS-1:0]);

            if (m_axis_tvalid && m_axis_tready) begin
                got.average  = m_axis_tdata[VALUE_BITS-1:0];
                got.tag.row  = m_axis_tdata[VALUE_BITS +: ROWS_W];
                got.tag.col  = m_axis_tdata[VALUE_BITS+ROWS_W +: COL_W];
                got.tag.last = m_axis_tlast;
                if (pending_averages.size() == 0) begin
                    faults++;
                    if (faults <= 10)
                        $display("[%0t] unexpected result beat: avg=%h row=%0d col=%0d last=%b",
                                 $realtime, got.average, got.tag.row, got.tag.col,
                                 got.tag.last);
                end else begin
                    want = pending_averages.pop_front();
                    if (got.average !== want.average || got.tag.row !== want.tag.row ||
                        got.tag.col !== want.tag.col || got.tag.last !== want.tag.last) begin
                        faults++;
                        if (faults <= 10)
                            $display(
                                "[%0t] exp/got avg %h/%h row %0d/%0d col %0d/%0d last %b/%b",
                                $realtime, want.average, got.average, want.tag.row,
                                got.tag.row, want.tag.col, got.tag.col, want.tag.last,
                                got.tag.last);
                    end else begin
                        matched++;
                    end
                end
            end
        end
        fault_count      <= faults;
        awaited          <= pending_averages.size();
        averages_checked <= matched;
    end

endmodule

[tb/sv/tb_top.sv]
// Testbench top for the five-point stencil: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 1ps
module tb_top;
    import jfps_pkg::*;

    localparam int     HOLD_CYCLES   = 300;
    localparam int     SETTLE_CYCLES = 8;
    localparam value_t MOST_NEGATIVE = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam value_t MOST_POSITIVE = {1'b0, {(VALUE_BITS-1){1'b1}}};

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [31:0] sample
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [31:0] average, [47:32] out_row,
                                                  // [56:48] out_col
    logic                   m_axis_tlast;
    logic                   cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index     = REG_ROW_LENGTH;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_orders = 0;
    int hold_served = 0;
    int hold_left   = 0;
    int values_sent = 0;
    int grids_set   = 0;
    int fault_count;
    int awaited;
    int averages_checked;

    jacobi_five_point_stencil u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    jfps_stencil_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tlast     (m_axis_tlast),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fault_count      (fault_count),
        .awaited          (awaited),
        .averages_checked (averages_checked)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // hold off for a long stretch on each new order, else stall at random
    always @(posedge aclk) begin
        if (hold_orders != hold_served) begin
            hold_served   <= hold_orders;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic value_t random_sample();
        case ($urandom_range(7))
            0: return MOST_NEGATIVE;
            1: return MOST_POSITIVE;
            2: return value_t'($urandom_range(512)) - value_t'(256);
            3: return {($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return value_t'($urandom);
        endcase
    endfunction

    task automatic send_value(input value_t v);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do @(posedge aclk); while (!s_axis_tready);
        values_sent++;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_value(random_sample());
    endtask

    // drop valid and wait until every predicted average has come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_grid(input int len, input int rows);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ROW_LENGTH;
        cfg_data  <= CFG_DATA_W'(len);
        @(posedge aclk);
        cfg_index <= REG_ROW_COUNT;
        cfg_data  <= CFG_DATA_W'(rows);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        grids_set++;
    endtask

    // whole grids only, so each new row length starts on a fresh grid
    task automatic random_grids(input int budget);
        int len, rows, span, target;
        target = values_sent + budget;
        while (values_sent < target) begin
            case ($urandom_range(9))
                0: begin
                    len  = $urandom_range(2);
                    rows = $urandom_range(2);
                end
                1: begin
                    len  = $urandom_range(40, 64);
                    rows = $urandom_range(3, 4);
                end
                default: begin
                    len  = $urandom_range(3, 12);
                    rows = $urandom_range(3, 10);
                end
            endcase
            set_grid(len, rows);
            span = (len < 3 ? 3 : len) * (rows < 3 ? 3 : rows);
            send_random($urandom_range(1, 2) * span);
            settle();
        end
    endtask

    initial begin
        value_t v;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct <= 27;
        rx_idle_pct <= 83;

        // 3x3 grids: neighbors all most negative, all most positive, then a floor case
        set_grid(0, 1);
        for (int g = 0; g < 3; g++) begin
            for (int k = 0; k < 9; k++) begin
                case (g)
                    0:       v = MOST_NEGATIVE;
                    1:       v = MOST_POSITIVE;
                    default: v = (k == 7) ? '0 : '1;
                endcase
                send_value((k % 2 == 0) ? random_sample() : v);
            end
        end
        settle();

        random_grids(160);

        // shrink the row count below the current row mid-grid: wrap to row 0
        set_grid(5, 65535);
        send_random(22);
        settle();
        set_grid(5, 3);
        send_random(13);
        settle();

        tx_idle_pct <= 83;
        rx_idle_pct <= 27;
        random_grids(160);

        // shrink the row length past the current column mid-grid: jump to next row
        set_grid(9, 6);
        send_random(34);
        settle();
        set_grid(5, 6);
        send_random(10);
        settle();

        tx_idle_pct <= 0;
        rx_idle_pct <= 0;

        // stall the receiver while values keep coming
        set_grid(6, 10);
        send_random(12);
        hold_orders <= hold_orders + 1;
        send_random(48);
        settle();

        // oversized row length clamps to the widest row, then finish the grid on short rows
        set_grid(1023, 3);
        send_random(MAX_ROW_LENGTH + 3);
        settle();
        set_grid(5, 3);
        send_random(7);
        settle();

        random_grids(160);

        $display("Sent %0d grid values over %0d grid settings; %0d averages matched.",
                 values_sent, grids_set, averages_checked);
        $display("Covered clamped and mid-grid geometry changes, value extremes and stalls.");
        if (fault_count == 0 && awaited == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
